[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/asg_pkg.sv]
// ----------------------------------------------------------------------------
// asg_pkg
// Types, widths and constants of the angle statistics gate.
// ----------------------------------------------------------------------------
package asg_pkg;

    localparam int CNT_W   = 16;              // node count
    localparam int ANG_W   = 16;              // signed Q2.14 angle
    localparam int SUM_W   = 32;              // angle sum
    localparam int SQS_W   = 48;              // sum of squares
    localparam int CFG_W   = 15;              // widest register
    localparam int MULT_W  = 4;
    localparam int WIN_W   = CFG_W + MULT_W;
    localparam int ACC_W   = SQS_W + CNT_W + 1; // n*sum2 - sum^2, signed
    localparam int RAD_W   = SQS_W + CNT_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DIVN_W  = ROOT_W + 1;
    localparam int CNTR_W  = 6;
    localparam int IDX_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MULT_W-1:0] RESET_MULT    = 4'd4;
    localparam logic [CFG_W-1:0]  RESET_SCATTER = 15'd6554;
    localparam logic [CFG_W-1:0]  RESET_FLOOR   = 15'd57;
    localparam logic [CFG_W-1:0]  RESET_CEILING = 15'd1638;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_TEST    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MULT    = 2'd0,
        REG_SCATTER = 2'd1,
        REG_FLOOR   = 2'd2,
        REG_CEILING = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_MUL_P,
        ST_MUL_S,
        ST_SQRT,
        ST_DIV_RMS,
        ST_FINISH
    } state_t;

    // (a + b + 1) >> 1, saturated to the 15-bit magnitude range
    function automatic logic [CFG_W-1:0] half_sum_sat(input logic [ANG_W-1:0] a,
                                                      input logic [ANG_W-1:0] b);
        logic [ANG_W+1:0] h;
        h = ({2'b00, a} + {2'b00, b} + 1'b1) >> 1;
        return (h > {3'b000, {CFG_W{1'b1}}}) ? {CFG_W{1'b1}} : h[CFG_W-1:0];
    endfunction

endpackage

[hw/rtl/angle_statistics_gate_core.sv]
// ----------------------------------------------------------------------------
// angle_statistics_gate_core
// Running mean and rms of link angles along a chain, and an angle gate.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the opcode (append, test, restart, nop), tdata the
// signed Q2.14 angle. Every transfer yields one result on m_*: match, window,
// average, spread and node count after the operation.
// Test, restart, nop and an append of the first node go straight to the finish
// step, which loads the output register. Any other append runs the bit-serial
// sequencer: the shared restoring divider for the average, and for three or more
// nodes the shift-add multiplier for n*sum2 - sum^2 and, if that is positive,
// the two-bit-per-step square root and the divider again for the rms.
// One item is in work at a time; s_tready is high while the sequencer is idle.
// The output register holds a result until the receiver takes it; the next
// item is taken meanwhile and its result waits in the finish step.
// Reset (aresetn low, synchronous) loads the register defaults and the empty
// chain. Configuration writes through cfg_we / cfg_index / cfg_data land at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module angle_statistics_gate_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [asg_pkg::S_DATA_W-1:0]    s_tdata,   // [15:0] angle
    input  logic [1:0]                      s_tuser,   // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] match, [15:1] window, [31:16] average, [46:32] spread,
    // [62:47] node_total, [63] zero
    output logic [asg_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [asg_pkg::IDX_W-1:0]       cfg_index,
    input  logic [asg_pkg::CFG_W-1:0]       cfg_data
);
    import asg_pkg::*;

    state_t state_reg, state_next;

    logic [MULT_W-1:0] mult_reg;
    logic [CFG_W-1:0]  scatter_reg, floor_reg, ceiling_reg;

    logic [CNT_W-1:0]         count_reg;
    logic signed [ANG_W-1:0]  prev_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SQS_W-1:0]         sqsum_reg;
    logic signed [ANG_W-1:0]  average_reg;
    logic [CFG_W-1:0]         spread_reg;
    logic                     match_reg;

    logic [CNTR_W-1:0]        cnt_reg;
    logic [DIVN_W-1:0]        div_num_reg;
    logic [CNT_W-1:0]         div_rem_reg;
    logic [CNT_W-1:0]         div_den_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [RAD_W-1:0]         mcand_reg;
    logic [ROOT_W-1:0]        mplier_reg;
    logic [REM_W-1:0]         sq_rem_reg;

    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;

    // control
    logic s_fire, out_free, out_load;
    opcode_t op;

    // append arithmetic on the incoming angle
    logic signed [ANG_W-1:0] ang;
    logic [ANG_W-1:0]        ang_mag, prev_mag;
    logic [2*ANG_W-1:0]      ang_sq;
    logic [CNT_W-1:0]        n_new;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_new;
    logic [SQS_W:0]          sq_wide;
    logic [SQS_W-1:0]        sq_new;
    logic [SUM_W-1:0]        sum_new_mag, sum_mag;

    // serial units
    logic [CNT_W:0]          div_trial;
    logic                    div_ge;
    logic [CNT_W-1:0]        div_rem_step;
    logic [DIVN_W-1:0]       div_num_step;
    logic signed [ACC_W-1:0] acc_step;
    logic                    d_positive;
    logic [REM_W+1:0]        sq_shift, sq_trial;
    logic                    sq_ge;
    logic [CNT_W-1:0]        n_minus1;

    logic [WIN_W-1:0]        win_full;
    logic [CFG_W-1:0]        window;
    logic [CFG_W-1:0]        rms_lo;
    logic [DIVN_W-1:0]       rms_clamp1;
    logic signed [ANG_W-1:0] avg_q;

    assign op     = opcode_t'(s_tuser);
    assign ang    = s_tdata[ANG_W-1:0];
    assign s_fire = s_tvalid && s_tready;

    assign ang_mag  = ang[ANG_W-1] ? ANG_W'(-ang) : ang;
    assign prev_mag = prev_reg[ANG_W-1] ? ANG_W'(-prev_reg) : prev_reg;
    assign n_new    = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-ANG_W){ang[ANG_W-1]}}, ang};
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_new = sum_wide[SUM_W-1:0];
        end
    end
    assign ang_sq      = ang_mag * ang_mag;
    assign sq_wide     = {1'b0, sqsum_reg} + {{(SQS_W+1-2*ANG_W){1'b0}}, ang_sq};
    assign sq_new      = sq_wide[SQS_W] ? {SQS_W{1'b1}} : sq_wide[SQS_W-1:0];
    assign sum_new_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : sum_new;
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
    assign n_minus1    = count_reg - 1'b1;

    // restoring divider, one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_num_reg[DIVN_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? CNT_W'(div_trial - {1'b0, div_den_reg})
                                 : div_trial[CNT_W-1:0];
    assign div_num_step = {div_num_reg[DIVN_W-2:0], div_ge};

    // shift-add multiplier: add n*sum2 partials, then subtract sum^2 partials
    always_comb begin
        acc_step = acc_reg;
        if (mplier_reg[0]) begin
            if (state_reg == ST_MUL_S) begin
                acc_step = acc_reg - $signed({1'b0, mcand_reg});
            end else begin
                acc_step = acc_reg + $signed({1'b0, mcand_reg});
            end
        end
    end
    assign d_positive = !acc_step[ACC_W-1] && (acc_step != '0);

    // square root, two radicand bits per cycle
    assign sq_shift = {sq_rem_reg, mcand_reg[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, mplier_reg, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;

    // saturate the signed average from the quotient magnitude
    always_comb begin
        if (sum_reg[SUM_W-1]) begin
            avg_q = (div_num_step > DIVN_W'(32768)) ? {1'b1, {(ANG_W-1){1'b0}}}
                                                    : ANG_W'(-div_num_step[ANG_W-1:0]);
        end else begin
            avg_q = (div_num_step > DIVN_W'(32767)) ? {1'b0, {(ANG_W-1){1'b1}}}
                                                    : div_num_step[ANG_W-1:0];
        end
    end
    assign rms_clamp1 = (div_num_step < {{(DIVN_W-CFG_W){1'b0}}, floor_reg})
                        ? {{(DIVN_W-CFG_W){1'b0}}, floor_reg} : div_num_step;
    assign rms_lo     = (rms_clamp1 > {{(DIVN_W-CFG_W){1'b0}}, ceiling_reg})
                        ? ceiling_reg : rms_clamp1[CFG_W-1:0];

    assign win_full = mult_reg * spread_reg;
    assign window   = (win_full > {{MULT_W{1'b0}}, scatter_reg}) ? scatter_reg
                                                               : win_full[CFG_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (op == OP_APPEND && n_new > CNT_W'(1)) begin
                        state_next = ST_DIV_AVG;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_AVG: begin
                if (cnt_reg == CNTR_W'(1)) begin
                    state_next = (count_reg > CNT_W'(2)) ? ST_MUL_P : ST_FINISH;
                end
            end
            ST_MUL_P: begin
                if (cnt_reg == CNTR_W'(1)) state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                if (cnt_reg == CNTR_W'(1)) state_next = d_positive ? ST_SQRT : ST_FINISH;
            end
            ST_SQRT: begin
                if (cnt_reg == CNTR_W'(1)) state_next = ST_DIV_RMS;
            end
            ST_DIV_RMS: begin
                if (cnt_reg == CNTR_W'(1)) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mult_reg     <= RESET_MULT;
            scatter_reg  <= RESET_SCATTER;
            floor_reg    <= RESET_FLOOR;
            ceiling_reg  <= RESET_CEILING;
            count_reg    <= '0;
            prev_reg     <= ANG_W'(RESET_SCATTER);
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            average_reg  <= ANG_W'(RESET_SCATTER);
            spread_reg   <= RESET_CEILING;
            match_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_MULT:    mult_reg    <= cfg_data[MULT_W-1:0];
                    REG_SCATTER: scatter_reg <= cfg_data;
                    REG_FLOOR:   floor_reg   <= cfg_data;
                    REG_CEILING: ceiling_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        match_reg <= 1'b0;
                        case (op)
                            OP_APPEND: begin
                                count_reg <= n_new;
                                prev_reg  <= ang;
                                sum_reg   <= sum_new;
                                sqsum_reg <= sq_new;
                                if (n_new <= CNT_W'(2)) begin
                                    spread_reg <= half_sum_sat(prev_mag, ang_mag);
                                end
                                if (n_new == CNT_W'(1)) begin
                                    average_reg <= ANG_W'(half_sum_sat(
                                                   ANG_W'(scatter_reg), ang_mag));
                                end
                                div_num_reg <= {1'b0, sum_new_mag}
                                             + DIVN_W'(n_new >> 1);
                                div_den_reg <= n_new;
                                div_rem_reg <= '0;
                                if (n_new > CNT_W'(1)) cnt_reg <= CNTR_W'(DIVN_W);
                            end
                            OP_TEST: begin
                                match_reg <= ang_mag < {1'b0, window};
                            end
                            OP_RESTART: begin
                                count_reg   <= '0;
                                prev_reg    <= ANG_W'(scatter_reg);
                                sum_reg     <= '0;
                                sqsum_reg   <= '0;
                                average_reg <= ANG_W'(scatter_reg);
                                spread_reg  <= ceiling_reg;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV_AVG: begin
                    div_num_reg <= div_num_step;
                    div_rem_reg <= div_rem_step;
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTR_W'(1)) begin
                        average_reg <= avg_q;
                        acc_reg     <= '0;
                        mcand_reg   <= RAD_W'(sqsum_reg);
                        mplier_reg  <= ROOT_W'(count_reg);
                        if (count_reg > CNT_W'(2)) cnt_reg <= CNTR_W'(CNT_W);
                    end
                end
                ST_MUL_P, ST_MUL_S: begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (state_reg == ST_MUL_P && cnt_reg == CNTR_W'(1)) begin
                        mcand_reg  <= RAD_W'(sum_mag);
                        mplier_reg <= sum_mag;
                        cnt_reg    <= CNTR_W'(SUM_W);
                    end
                    if (state_reg == ST_MUL_S && cnt_reg == CNTR_W'(1)) begin
                        mcand_reg  <= acc_step[RAD_W-1:0];
                        mplier_reg <= '0;
                        sq_rem_reg <= '0;
                        if (d_positive) begin
                            cnt_reg <= CNTR_W'(ROOT_W);
                        end else begin
                            spread_reg <= floor_reg;
                        end
                    end
                end
                ST_SQRT: begin
                    sq_rem_reg <= sq_ge ? REM_W'(sq_shift - sq_trial) : REM_W'(sq_shift);
                    mplier_reg <= {mplier_reg[ROOT_W-2:0], sq_ge};
                    mcand_reg  <= mcand_reg << 2;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTR_W'(1)) begin
                        div_num_reg <= {1'b0, mplier_reg[ROOT_W-2:0], sq_ge}
                                     + DIVN_W'(n_minus1 >> 1);
                        div_den_reg <= n_minus1;
                        div_rem_reg <= '0;
                        cnt_reg     <= CNTR_W'(DIVN_W);
                    end
                end
                ST_DIV_RMS: begin
                    div_num_reg <= div_num_step;
                    div_rem_reg <= div_rem_step;
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTR_W'(1)) spread_reg <= rms_lo;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, count_reg, spread_reg, average_reg, window, match_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_ALWAYS(a_cnt_idle, aclk, aresetn,
        (state_reg != ST_IDLE && state_reg != ST_FINISH) || cnt_reg == '0)
    `ASSERT_NEXT(a_count_step, aclk, aresetn,
        s_fire && op == OP_APPEND && count_reg != COUNT_MAX,
        count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_finish_loads, aclk, aresetn,
        state_reg == ST_FINISH && (!m_tvalid || m_tready), m_tvalid)

endmodule

[dv/angle_statistics_gate_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_statistics_gate_checker
// Watches the input, result and register-write ports of the angle statistics
// gate, predicts every result from its own copy of the chain statistics and
// compares it field by field, in order, with what the block produces.
// ----------------------------------------------------------------------------
module angle_statistics_gate_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [asg_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [asg_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [asg_pkg::IDX_W-1:0]       cfg_index,
    input  logic [asg_pkg::CFG_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import asg_pkg::*;

    // most significant field first, so match lands in the lowest bit
    typedef struct packed {
        logic [15:0] node_total;
        logic [14:0] spread;
        logic [15:0] average;
        logic [14:0] window;
        logic        match;
    } gate_status_t;

    logic [3:0]  mult_q;
    logic [14:0] scatter_q, floor_q, ceiling_q;

    longint unsigned node_cnt;
    longint          last_angle;
    longint          angle_sum;
    longint unsigned square_sum;
    longint          avg_q;
    longint unsigned spread_q;

    gate_status_t status_queue[$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned half_sum(input longint unsigned a,
                                                 input longint unsigned b);
        longint unsigned h;
        h = (a + b + 1) >> 1;
        return (h > 32767) ? 32767 : h;
    endfunction

    function automatic longint unsigned gate_window();
        longint unsigned w;
        w = mult_q * spread_q;
        return (w > scatter_q) ? 64'(scatter_q) : w;
    endfunction

    function automatic void clear_chain();
        node_cnt   = 0;
        last_angle = longint'(scatter_q);
        angle_sum  = 0;
        square_sum = 0;
        avg_q      = longint'(scatter_q);
        spread_q   = 64'(ceiling_q);
    endfunction

    function automatic logic [79:0] root_floor(input logic [79:0] d);
        logic [79:0] r, c;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            c = r | (80'd1 << b);
            if (c * c <= d) r = c;
        end
        return r;
    endfunction

    function automatic void add_node(input longint a);
        longint unsigned n, am, q, s2;
        longint          s, avg;
        logic [79:0]     p, root, r;
        am = magnitude(a);
        n  = (node_cnt < 65535) ? node_cnt + 1 : 65535;
        s  = angle_sum + a;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        square_sum = square_sum + am * am;
        if (square_sum > 64'hFFFF_FFFF_FFFF) square_sum = 64'hFFFF_FFFF_FFFF;
        q   = (magnitude(s) + n / 2) / n;
        avg = (s < 0) ? -longint'(q) : longint'(q);
        if (avg > 32767) avg = 32767;
        if (avg < -32768) avg = -32768;
        if (n > 2) begin
            p  = 80'(n) * 80'(square_sum);
            s2 = magnitude(s) * magnitude(s);
            if (p <= 80'(s2)) begin
                spread_q = 64'(floor_q);
            end else begin
                root = root_floor(p - 80'(s2));
                r = (root + 80'((n - 1) / 2)) / 80'(n - 1);
                if (r < 80'(floor_q)) r = 80'(floor_q);
                if (r > 80'(ceiling_q)) r = 80'(ceiling_q);
                spread_q = 64'(r);
            end
        end else begin
            if (n == 1) avg = half_sum(scatter_q, am);
            spread_q = half_sum(magnitude(last_angle), am);
        end
        node_cnt   = n;
        last_angle = a;
        angle_sum  = s;
        avg_q      = avg;
    endfunction

    function automatic gate_status_t gate_step(input opcode_t op, input logic [15:0] raw);
        gate_status_t st;
        longint       a;
        a = longint'($signed(raw));
        st.match = 1'b0;
        case (op)
            OP_APPEND:  add_node(a);
            OP_TEST:    st.match = (magnitude(a) < gate_window());
            OP_RESTART: clear_chain();
            default: ;
        endcase
        st.window     = gate_window();
        st.average    = avg_q[15:0];
        st.spread     = spread_q[14:0];
        st.node_total = node_cnt[15:0];
        return st;
    endfunction

    always @(posedge aclk) begin
        gate_status_t exp_st, got;
        if (!aresetn) begin
            mult_q    = RESET_MULT;
            scatter_q = RESET_SCATTER;
            floor_q   = RESET_FLOOR;
            ceiling_q = RESET_CEILING;
            clear_chain();
            status_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_MULT:    mult_q    = cfg_data[3:0];
                    REG_SCATTER: scatter_q = cfg_data;
                    REG_FLOOR:   floor_q   = cfg_data;
                    REG_CEILING: ceiling_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                status_queue.push_back(gate_step(opcode_t'(s_tuser), s_tdata[15:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[62:0];
                if (status_queue.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_st = status_queue.pop_front();
                    if (got.match !== exp_st.match) begin
                        $error("match: expected %0d, got %0d", exp_st.match, got.match);
                        fail_count++;
                    end
                    if (got.window !== exp_st.window) begin
                        $error("window: expected %0d, got %0d", exp_st.window, got.window);
                        fail_count++;
                    end
                    if (got.average !== exp_st.average) begin
                        $error("average: expected %0d, got %0d",
                               $signed(exp_st.average), $signed(got.average));
                        fail_count++;
                    end
                    if (got.spread !== exp_st.spread) begin
                        $error("spread: expected %0d, got %0d", exp_st.spread, got.spread);
                        fail_count++;
                    end
                    if (got.node_total !== exp_st.node_total) begin
                        $error("node_total: expected %0d, got %0d",
                               exp_st.node_total, got.node_total);
                        fail_count++;
                    end
                end
            end
        end
        pending = status_queue.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the angle statistics gate: directed corner items,
// then random chains under several register settings, with random idling on
// both streams, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import asg_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = OP_NOP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_MULT;
    logic [CFG_W-1:0]    cfg_data = '0;

    int  fail_count;
    int  pending;
    bit  no_idle = 0;
    int  hold_off = 0;

    always #1 aclk = ~aclk;

    angle_statistics_gate_core dut (.*);

    angle_statistics_gate_checker checker_i (.*);

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall per transfer, optional long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (hold_off > 0) begin
                gap = hold_off;
                hold_off = 0;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input opcode_t op, input logic [15:0] ang);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ang;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input int m, input int sc, input int fl, input int ce);
        write_reg(REG_MULT, CFG_W'(m));
        write_reg(REG_SCATTER, CFG_W'(sc));
        write_reg(REG_FLOOR, CFG_W'(fl));
        write_reg(REG_CEILING, CFG_W'(ce));
    endtask

    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'($signed($urandom_range(0, 1200)) - 600);
        if (sel < 8) return 16'($signed($urandom_range(0, 8000)) - 4000);
        if (sel == 8) return 16'($urandom());
        return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic random_items(input int count);
        int sel;
        opcode_t op;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 58)      op = OP_APPEND;
            else if (sel < 90) op = OP_TEST;
            else if (sel < 96) op = OP_RESTART;
            else               op = OP_NOP;
            if (i % 100 == 40) no_idle = 1;
            if (i % 100 == 60) no_idle = 0;
            send_item(op, pick_angle());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: early nodes, extremes, zero-variance chain, every opcode
        send_item(OP_TEST, 16'h0000);
        send_item(OP_APPEND, 16'h7FFF);
        send_item(OP_TEST, 16'h8000);
        send_item(OP_APPEND, 16'h8000);
        send_item(OP_APPEND, 16'h0000);
        send_item(OP_TEST, 16'h7FFF);
        send_item(OP_NOP, 16'hFFFF);
        send_item(OP_RESTART, 16'h1234);
        for (int i = 0; i < 5; i++) send_item(OP_APPEND, 16'd300);
        send_item(OP_TEST, 16'd299);
        send_item(OP_TEST, 16'hFED4);
        send_item(OP_RESTART, 16'h0000);
        send_item(OP_APPEND, 16'hFFFF);
        send_item(OP_APPEND, 16'h0001);
        send_item(OP_APPEND, 16'hFFFE);
        send_item(OP_TEST, 16'h0000);
        drain();

        // full window, no floor
        set_regs(15, 32767, 0, 32767);
        send_item(OP_RESTART, 16'h0000);
        random_items(300);

        // long receiver hold-off fills the block and stalls the input
        hold_off = 400;
        random_items(40);
        drain();

        // floor above ceiling, zero scatter
        set_regs(1, 0, 32767, 0);
        send_item(OP_RESTART, 16'h0000);
        random_items(300);
        drain();

        // reset-style values
        set_regs(4, 6554, 57, 1638);
        send_item(OP_RESTART, 16'h0000);
        random_items(300);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_regs($urandom_range(1, 15), $urandom_range(0, 32767),
                     $urandom_range(0, 200), $urandom_range(100, 32767));
            random_items(250);
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
